### design/kda_pkg.sv
// ---------------------------------------------------------------------------
// kda_pkg
// Shared codes and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_BLOCK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES       = 2'd3;

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_FORMAT = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_READ_ONLY = 3'd2;
  localparam logic [2:0] ST_MEDIA     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // record header: two 32-bit words
  localparam logic [17:0] HEADER_BYTES = 18'd8;

  typedef struct packed {
    logic       load_item;
    logic       scan_clr;
    logic       idx_inc;
    logic       dir_rd;
    logic       dir_del;
    logic       free_note;
    logic       slot_take;
    logic       dir_rec;
    logic       wp_adv;
    logic       bidx_fdb;
    logic       bidx_zero;
    logic       bidx_inc;
    logic       blk_rd;
    logic       blk_take;
    logic       blk_fmt;
    logic       fmt_regs;
    logic       set_ro;
    logic       page_ent;
    logic       page_save;
    logic       clr_step;
    logic       res_load;
    logic       res_page;
    logic [2:0] res_code;
  } kda_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       merr;
    logic       too_big;
    logic       rd_eq;
    logic       rd_valid;
    logic       idx_last;
    logic       have_free;
    logic       ro_state;
    logic       wrap;
    logic       blk_none;
    logic       blk_vacant;
    logic       blk_last;
    logic       bidx_last;
    logic       clr_last;
  } kda_sts_t;

endpackage

`default_nettype wire

### design/kda_dpath.sv
// ---------------------------------------------------------------------------
// kda_dpath
// Directory and block-map memories, write point, config and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kda_dpath #(
  parameter int DIR_ENTRIES = 64,
  parameter int MAX_BLOCKS  = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [kda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kda_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [2:0]                   op,
  input  wire logic [31:0]                  key_hash,
  input  wire logic [15:0]                  key_length,
  input  wire logic [15:0]                  value_length,
  input  wire logic                         media_error,
  input  wire kda_pkg::kda_cmd_t            cmd,
  output kda_pkg::kda_sts_t                 sts,
  output logic [2:0]                        status,
  output logic [11:0]                       page_num,
  output logic                              read_only_now
);
  import kda_pkg::*;

  localparam int IW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = (BW + 1 > 7) ? BW + 1 : 7;
  localparam int CN  = (DIR_ENTRIES > MAX_BLOCKS) ? DIR_ENTRIES : MAX_BLOCKS;
  localparam int CLW = (CN > 1) ? $clog2(CN) : 1;
  localparam int PW  = (BW + 8 > 12) ? BW + 8 : 12;

  typedef struct packed {
    logic [31:0]   hash;
    logic          valid;
    logic [BW-1:0] blk;
    logic [6:0]    pg;
  } dir_ent_t;

  // config
  logic [6:0]  pages_in_block;
  logic [6:0]  block_count;
  logic [5:0]  first_data_block;
  logic [15:0] page_bytes;

  // item
  logic [2:0]  item_op;
  logic [31:0] item_hash;
  logic [15:0] item_klen;
  logic [15:0] item_vlen;
  logic        item_merr;

  // allocator
  logic [BW-1:0] write_block;
  logic [6:0]    write_page_offset;
  logic          ro_state;
  logic [BW-1:0] save_blk;
  logic [6:0]    save_pg;

  // scan
  logic [IW-1:0]  idx;
  logic [IW-1:0]  slot;
  logic           have_free;
  logic [BW-1:0]  bidx;
  logic [CLW-1:0] clr;
  logic [11:0]    page_reg;

  dir_ent_t dir_mem [DIR_ENTRIES];
  dir_ent_t dir_rdata;
  logic     blk_mem [MAX_BLOCKS];
  logic     blk_rdata;

  logic [6:0]    wpo_inc;
  logic [CW-1:0] lim;
  logic          clr_in_dir;
  logic          clr_in_blk;
  logic [BW-1:0] pb_sel;
  logic [6:0]    pp_sel;
  logic [PW-1:0] page_sum;

  assign wpo_inc    = write_page_offset + 7'd1;
  assign lim        = (CW'(block_count) < CW'(MAX_BLOCKS)) ? CW'(block_count) : CW'(MAX_BLOCKS);
  assign clr_in_dir = ({1'b0, clr} < (CLW+1)'(DIR_ENTRIES));
  assign clr_in_blk = ({1'b0, clr} < (CLW+1)'(MAX_BLOCKS));
  assign pb_sel     = cmd.page_ent ? dir_rdata.blk : save_blk;
  assign pp_sel     = cmd.page_ent ? dir_rdata.pg : save_pg;
  assign page_sum   = PW'(pb_sel) * PW'(pages_in_block) + PW'(pp_sel);

  always_comb begin
    sts.op         = item_op;
    sts.merr       = item_merr;
    sts.too_big    = (18'(item_klen) + 18'(item_vlen) + HEADER_BYTES) > 18'(page_bytes);
    sts.rd_eq      = (dir_rdata.hash == item_hash);
    sts.rd_valid   = dir_rdata.valid;
    sts.idx_last   = (idx == IW'(DIR_ENTRIES - 1));
    sts.have_free  = have_free;
    sts.ro_state   = ro_state;
    sts.wrap       = (wpo_inc >= pages_in_block);
    sts.blk_none   = (CW'(first_data_block) >= lim);
    sts.blk_vacant = !blk_rdata;
    sts.blk_last   = ((CW'(bidx) + CW'(1)) >= lim);
    sts.bidx_last  = (bidx == BW'(MAX_BLOCKS - 1));
    sts.clr_last   = (clr == CLW'(CN - 1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_block    <= 7'd64;
      block_count       <= 7'd64;
      first_data_block  <= 6'd0;
      page_bytes        <= 16'd2048;
      write_block       <= '0;
      write_page_offset <= '0;
      ro_state          <= 1'b0;
      have_free         <= 1'b0;
      clr               <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGES_IN_BLOCK:   pages_in_block   <= cfg_data[6:0];
          CFG_BLOCK_COUNT:      block_count      <= cfg_data[6:0];
          CFG_FIRST_DATA_BLOCK: first_data_block <= cfg_data[5:0];
          CFG_PAGE_BYTES:       page_bytes       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_step) clr <= clr + CLW'(1);
      if (cmd.scan_clr) have_free <= 1'b0;
      else if (cmd.free_note) have_free <= 1'b1;
      if (cmd.set_ro) ro_state <= 1'b1;
      if (cmd.wp_adv) write_page_offset <= wpo_inc;
      if (cmd.blk_take) begin
        write_block       <= bidx;
        write_page_offset <= '0;
      end
      if (cmd.fmt_regs) begin
        write_block       <= '0;
        write_page_offset <= '0;
        ro_state          <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= op;
      item_hash <= key_hash;
      item_klen <= key_length;
      item_vlen <= value_length;
      item_merr <= media_error;
    end
    if (cmd.scan_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + IW'(1);
    if (cmd.free_note || cmd.slot_take) slot <= idx;
    if (cmd.wp_adv) begin
      save_blk <= write_block;
      save_pg  <= write_page_offset;
    end
    if (cmd.bidx_fdb) bidx <= BW'(first_data_block);
    else if (cmd.bidx_zero) bidx <= '0;
    else if (cmd.bidx_inc) bidx <= bidx + BW'(1);
    if (cmd.page_ent || cmd.page_save) page_reg <= page_sum[11:0];
    if (cmd.res_load) begin
      status        <= cmd.res_code;
      page_num      <= cmd.res_page ? page_reg : 12'd0;
      read_only_now <= ro_state;
    end
  end

  // directory memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (clr_in_dir) dir_mem[clr[IW-1:0]] <= '0;
    end else if (cmd.dir_del) begin
      dir_mem[idx] <= '{hash: item_hash, valid: 1'b0, blk: '0, pg: '0};
    end else if (cmd.dir_rec) begin
      dir_mem[slot] <= '{hash: item_hash, valid: 1'b1, blk: save_blk, pg: save_pg};
    end
    if (cmd.dir_rd) dir_rdata <= dir_mem[idx];
  end

  // block map memory: 1 = in use
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (clr_in_blk) blk_mem[clr[BW-1:0]] <= (clr == '0);
    end else if (cmd.blk_fmt) begin
      blk_mem[bidx] <= (bidx == '0);
    end else if (cmd.blk_take) begin
      blk_mem[bidx] <= 1'b1;
    end
    if (cmd.blk_rd) blk_rdata <= blk_mem[bidx];
  end

endmodule

`default_nettype wire

### design/kda_ctrl.sv
// ---------------------------------------------------------------------------
// kda_ctrl
// Sequencer: walks the directory and block map for each operation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kda_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kda_pkg::kda_cmd_t      cmd,
  input  wire kda_pkg::kda_sts_t sts
);
  import kda_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SIZE, S_FV_RD, S_FV_CHK, S_ST_RD, S_ST_CHK,
    S_GATE, S_BK_RD, S_BK_CHK, S_REC, S_FMT, S_DONE
  } state_t;

  state_t     state, state_next;
  logic [2:0] res_code;
  logic       res_page;
  logic       fin;
  logic [2:0] fin_code;
  logic       fin_page;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    fin        = 1'b0;
    fin_code   = ST_OK;
    fin_page   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_SET: state_next = S_SIZE;
          OP_GET, OP_DELETE, OP_UPDATE: begin
            cmd.scan_clr = 1'b1;
            state_next   = S_FV_RD;
          end
          OP_FORMAT: begin
            if (sts.merr) begin
              fin      = 1'b1;
              fin_code = ST_MEDIA;
            end else begin
              cmd.bidx_zero = 1'b1;
              state_next    = S_FMT;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_SIZE: begin
        if (sts.too_big) begin
          fin      = 1'b1;
          fin_code = ST_TOO_BIG;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_ST_RD;
        end
      end
      S_FV_RD: begin
        cmd.dir_rd = 1'b1;
        state_next = S_FV_CHK;
      end
      S_FV_CHK: begin
        if (sts.rd_valid && sts.rd_eq) begin
          case (sts.op)
            OP_GET: begin
              fin = 1'b1;
              if (sts.merr) begin
                fin_code = ST_MEDIA;
              end else begin
                cmd.page_ent = 1'b1;
                fin_page     = 1'b1;
              end
            end
            OP_DELETE: begin
              cmd.dir_del = 1'b1;
              fin         = 1'b1;
            end
            default: begin
              // update: drop the old entry, then run a set
              cmd.dir_del = 1'b1;
              state_next  = S_SIZE;
            end
          endcase
        end else if (sts.idx_last) begin
          fin      = 1'b1;
          fin_code = ST_NOT_FOUND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FV_RD;
        end
      end
      S_ST_RD: begin
        cmd.dir_rd = 1'b1;
        state_next = S_ST_CHK;
      end
      S_ST_CHK: begin
        // a hash match wins whether valid or not; else first deleted slot
        if (sts.rd_eq) begin
          cmd.dir_del   = 1'b1;
          cmd.slot_take = 1'b1;
          state_next    = S_GATE;
        end else begin
          cmd.free_note = !sts.rd_valid && !sts.have_free;
          if (sts.idx_last) begin
            if (sts.have_free || !sts.rd_valid) begin
              state_next = S_GATE;
            end else begin
              cmd.set_ro = 1'b1;
              fin        = 1'b1;
              fin_code   = ST_READ_ONLY;
            end
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_ST_RD;
          end
        end
      end
      S_GATE: begin
        if (sts.ro_state) begin
          fin      = 1'b1;
          fin_code = ST_READ_ONLY;
        end else if (sts.merr) begin
          fin      = 1'b1;
          fin_code = ST_MEDIA;
        end else begin
          cmd.wp_adv = 1'b1;
          if (!sts.wrap) begin
            state_next = S_REC;
          end else if (sts.blk_none) begin
            cmd.set_ro = 1'b1;
            fin        = 1'b1;
            fin_code   = ST_READ_ONLY;
          end else begin
            cmd.bidx_fdb = 1'b1;
            state_next   = S_BK_RD;
          end
        end
      end
      S_BK_RD: begin
        cmd.blk_rd = 1'b1;
        state_next = S_BK_CHK;
      end
      S_BK_CHK: begin
        if (sts.blk_vacant) begin
          cmd.blk_take = 1'b1;
          state_next   = S_REC;
        end else if (sts.blk_last) begin
          cmd.set_ro = 1'b1;
          fin        = 1'b1;
          fin_code   = ST_READ_ONLY;
        end else begin
          cmd.bidx_inc = 1'b1;
          state_next   = S_BK_RD;
        end
      end
      S_REC: begin
        cmd.dir_rec   = 1'b1;
        cmd.page_save = 1'b1;
        fin           = 1'b1;
        fin_page      = 1'b1;
      end
      S_FMT: begin
        cmd.blk_fmt = 1'b1;
        if (sts.bidx_last) begin
          cmd.fmt_regs = 1'b1;
          fin          = 1'b1;
        end else begin
          cmd.bidx_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.res_code = res_code;
        cmd.res_page = res_page;
        if (!(out_valid && out_stall)) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) state_next = S_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (fin) begin
        res_code <= fin_code;
        res_page <= fin_page;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while full");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_single_dir_write: assert property (@(posedge clk) disable iff (rst)
    cmd.dir_rec |-> !(cmd.dir_del || cmd.clr_step))
    else $error("two directory writes in one cycle");

  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid && (state == S_IDLE))
    else $error("result not presented");

endmodule

`default_nettype wire

### design/flash_key_directory_allocator.sv
// ---------------------------------------------------------------------------
// flash_key_directory_allocator
// Key-hash directory with a log-order flash page allocator.
// ---------------------------------------------------------------------------
//  channel | signals                                       | direction
//  in      | in_valid, in_stall, op, key_hash, key_length, | item in
//          | value_length, media_error                     |
//  out     | out_valid, out_stall, status, page_num,       | result out
//          | read_only_now                                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data     | register write
//
//  One item at a time; the directory walk reads each entry from memory, then
//  compares it, and the block search reads and checks each block in turn.
//  After reset both memories are swept with in_stall high. The next item is
//  taken while a result waits on out_stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flash_key_directory_allocator #(
  parameter int DIR_ENTRIES = 64,
  parameter int MAX_BLOCKS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    op,
  input  wire logic [31:0]                   key_hash,
  input  wire logic [15:0]                   key_length,
  input  wire logic [15:0]                   value_length,
  input  wire logic                          media_error,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         status,
  output logic [11:0]                        page_num,
  output logic                               read_only_now,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kda_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kda_pkg::*;

  kda_cmd_t cmd;
  kda_sts_t sts;

  assign cfg_ready = 1'b1;

  kda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  kda_dpath #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .key_hash      (key_hash),
    .key_length    (key_length),
    .value_length  (value_length),
    .media_error   (media_error),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .page_num      (page_num),
    .read_only_now (read_only_now)
  );

endmodule

`default_nettype wire
